// ----- rtl/ir_pulse_width_command_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// ir_pulse_width_command_decoder_defines
// Assertion macros shared by the decoder modules; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_WIDTH_COMMAND_DECODER_DEFINES_SVH
`define IR_PULSE_WIDTH_COMMAND_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define IRPWD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("irpwd assertion failed");
// condition that must never be seen outside reset
`define IRPWD_NEVER(label, cond) \
    `IRPWD_ASSERT(label, !(cond))
`else
`define IRPWD_ASSERT(label, prop)
`define IRPWD_NEVER(label, cond)
`endif

`endif

// ----- rtl/irpwd_pkg.sv -----
// ----------------------------------------------------------------------------
// irpwd_pkg
// Types, constants and helpers for the IR pulse-width command decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package irpwd_pkg;

    // number of marks read per frame
    localparam int CODE_BITS = 7;
    // width of the emitted command code
    localparam int CMD_W     = 7;
    // bit counter holds 0 .. CODE_BITS
    localparam int BP_W      = $clog2(CODE_BITS + 1);
    // index into the collected code
    localparam int BI_W      = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
    localparam int TICK_W    = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_INIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_RELOAD = 3'd5;

    // register reset values
    localparam logic [TICK_W-1:0] RST_START_MIN    = 8'd6;
    localparam logic [TICK_W-1:0] RST_START_MAX    = 8'd9;
    localparam logic [TICK_W-1:0] RST_SPACE_MAX    = 8'd3;
    localparam logic [TICK_W-1:0] RST_ONE_MIN      = 8'd3;
    localparam logic [TICK_W-1:0] RST_QUIET_INIT   = 8'd67;
    localparam logic [TICK_W-1:0] RST_QUIET_RELOAD = 8'd111;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SPACE = 3'd1,
        PH_MARK  = 3'd2,
        PH_QUIET = 3'd3
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] start_min;
        logic [TICK_W-1:0] start_max;
        logic [TICK_W-1:0] space_max;
        logic [TICK_W-1:0] one_min;
        logic [TICK_W-1:0] quiet_init;
        logic [TICK_W-1:0] quiet_reload;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] code;
        logic             error;
    } t_result;

    // saturating run counter step
    function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
        return (v == TICK_MAX) ? v : v + 1'b1;
    endfunction

    // low CMD_W bits of the collected code, zero filled for short codes
    function automatic logic [CMD_W-1:0] to_cmd(input logic [CODE_BITS-1:0] c);
        logic [CODE_BITS+CMD_W-1:0] wide;
        wide = {{CMD_W{1'b0}}, c};
        return wide[CMD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ir_pulse_width_command_decoder.sv -----
// ----------------------------------------------------------------------------
// ir_pulse_width_command_decoder
// Pulse-width IR command decoder: one line sample per tick in, one command
// or framing error out per completed or broken frame.
//
//   channel  | dir | payload
//   ---------+-----+------------------------------------------------
//   s_axis   | in  | tdata[0] line_level, tdata[7:1] zero
//   m_axis   | out | tdata[6:0] command_code, tdata[7] zero,
//            |     | tuser frame_error
//   cfg      | in  | i_cfg_we / i_cfg_index / i_cfg_wdata, 8-bit registers
//
// One sample is taken every cycle unless held off; its result, if any, shows
// on m_axis in the next cycle from a single output register.
// A sample is held off only while that register is full and m_axis stalls.
// Reset (synchronous, active low) loads the register defaults and returns the
// frame state machine to hunting for a start mark.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_width_command_decoder (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // stream in
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [0] line_level
    // stream out
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [7:0]                           m_axis_tdata,  // [6:0] command_code
    output logic                                 m_axis_tuser,  // [0] frame_error
    // configuration writes
    input  wire logic                            i_cfg_we,
    input  wire logic [irpwd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [irpwd_pkg::TICK_W-1:0]    i_cfg_wdata
);
    import irpwd_pkg::*;

    t_cfg             cfg;
    t_result          result;
    logic             in_ready;
    logic             accept;
    logic [CMD_W-1:0] out_code;

    assign accept        = s_axis_tvalid && in_ready;
    assign s_axis_tready = in_ready;

    irpwd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    irpwd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (accept),
        .i_line_level (s_axis_tdata[0]),
        .i_cfg        (cfg),
        .o_result     (result)
    );

    irpwd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (in_ready),
        .o_valid     (m_axis_tvalid),
        .o_code      (out_code),
        .o_error     (m_axis_tuser)
    );

    // pad the code to a whole byte
    assign m_axis_tdata = {1'b0, out_code};

endmodule

`default_nettype wire

// ----- rtl/irpwd_cfg.sv -----
// ----------------------------------------------------------------------------
// irpwd_cfg
// Configuration register bank written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module irpwd_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [irpwd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [irpwd_pkg::TICK_W-1:0]   i_cfg_wdata,
    output irpwd_pkg::t_cfg                     o_cfg
);
    import irpwd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode the write, unknown indexes leave everything as is
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_MIN:    n_cfg.start_min    = i_cfg_wdata;
                CFG_START_MAX:    n_cfg.start_max    = i_cfg_wdata;
                CFG_SPACE_MAX:    n_cfg.space_max    = i_cfg_wdata;
                CFG_ONE_MIN:      n_cfg.one_min      = i_cfg_wdata;
                CFG_QUIET_INIT:   n_cfg.quiet_init   = i_cfg_wdata;
                CFG_QUIET_RELOAD: n_cfg.quiet_reload = i_cfg_wdata;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_min    <= RST_START_MIN;
            r_cfg.start_max    <= RST_START_MAX;
            r_cfg.space_max    <= RST_SPACE_MAX;
            r_cfg.one_min      <= RST_ONE_MIN;
            r_cfg.quiet_init   <= RST_QUIET_INIT;
            r_cfg.quiet_reload <= RST_QUIET_RELOAD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/irpwd_core.sv -----
// ----------------------------------------------------------------------------
// irpwd_core
// Frame state machine: start window, space limit, mark decode, quiet count.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ir_pulse_width_command_decoder_defines.svh"

module irpwd_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_line_level,
    input  wire irpwd_pkg::t_cfg i_cfg,
    output irpwd_pkg::t_result  o_result
);
    import irpwd_pkg::*;

    t_phase                r_phase,  n_phase;
    logic [TICK_W-1:0]     r_run,    n_run;
    logic [BP_W-1:0]       r_bitpos, n_bitpos;
    logic [CODE_BITS-1:0]  r_code,   n_code;
    logic [TICK_W-1:0]     r_quiet,  n_quiet;

    logic                  low;
    logic [TICK_W-1:0]     run_inc;
    logic [BP_W-1:0]       bitpos_inc;
    logic [CODE_BITS-1:0]  code_mark;
    logic                  start_ok;
    logic                  space_zero;
    logic [TICK_W-1:0]     quiet_base;
    logic [TICK_W-1:0]     quiet_dec;
    logic                  emit;
    logic                  emit_err;

    assign low        = !i_line_level;
    assign run_inc    = sat_inc(r_run);
    assign bitpos_inc = r_bitpos + 1'b1;
    assign start_ok   = (r_run != '0) && (r_run >= i_cfg.start_min)
                        && (r_run <= i_cfg.start_max);
    assign space_zero = (i_cfg.space_max == '0);

    // code with the bit of the mark that just ended
    always_comb begin
        code_mark = r_code;
        if (r_run >= i_cfg.one_min) begin
            code_mark[r_bitpos[BI_W-1:0]] = 1'b1;
        end
    end

    // quiet tick: a low sample reloads, entry from a mark loads the initial count
    always_comb begin
        if (r_phase == PH_MARK) begin
            quiet_base = i_cfg.quiet_init;
        end else if (low) begin
            quiet_base = i_cfg.quiet_reload;
        end else begin
            quiet_base = r_quiet;
        end
        quiet_dec = (quiet_base != '0) ? quiet_base - 1'b1 : quiet_base;
    end

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_run    = r_run;
        n_bitpos = r_bitpos;
        n_code   = r_code;
        n_quiet  = r_quiet;
        case (r_phase)
            PH_HUNT: begin
                if (low) begin
                    n_run = run_inc;
                end else if (start_ok && !space_zero) begin
                    n_phase  = PH_SPACE;
                    n_run    = 8'd1;
                    n_bitpos = '0;
                    n_code   = '0;
                end else begin
                    n_run = '0;
                end
            end
            PH_SPACE: begin
                if (low) begin
                    n_phase = PH_MARK;
                    n_run   = 8'd1;
                end else if (run_inc > i_cfg.space_max) begin
                    n_phase = PH_HUNT;
                    n_run   = '0;
                    n_bitpos = '0;
                    n_code  = '0;
                    n_quiet = '0;
                end else begin
                    n_run = run_inc;
                end
            end
            PH_MARK: begin
                if (low) begin
                    n_run = run_inc;
                end else if (bitpos_inc < BP_W'(CODE_BITS)) begin
                    if (space_zero) begin
                        n_phase  = PH_HUNT;
                        n_run    = '0;
                        n_bitpos = '0;
                        n_code   = '0;
                        n_quiet  = '0;
                    end else begin
                        n_phase  = PH_SPACE;
                        n_run    = 8'd1;
                        n_bitpos = bitpos_inc;
                        n_code   = code_mark;
                    end
                end else if (quiet_dec == '0) begin
                    n_phase  = PH_HUNT;
                    n_run    = '0;
                    n_bitpos = '0;
                    n_code   = '0;
                    n_quiet  = '0;
                end else begin
                    n_phase  = PH_QUIET;
                    n_run    = '0;
                    n_bitpos = bitpos_inc;
                    n_code   = code_mark;
                    n_quiet  = quiet_dec;
                end
            end
            PH_QUIET: begin
                if (quiet_dec == '0) begin
                    n_phase  = PH_HUNT;
                    n_run    = '0;
                    n_bitpos = '0;
                    n_code   = '0;
                    n_quiet  = '0;
                end else begin
                    n_quiet = quiet_dec;
                end
            end
            default: begin
                n_phase  = PH_HUNT;
                n_run    = '0;
                n_bitpos = '0;
                n_code   = '0;
                n_quiet  = '0;
            end
        endcase
    end

    // result outputs
    always_comb begin
        emit     = 1'b0;
        emit_err = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                emit_err = !low && start_ok && space_zero;
            end
            PH_SPACE: begin
                emit_err = !low && (run_inc > i_cfg.space_max);
            end
            PH_MARK: begin
                if (!low) begin
                    if (bitpos_inc < BP_W'(CODE_BITS)) begin
                        emit_err = space_zero;
                    end else begin
                        emit = (quiet_dec == '0);
                    end
                end
            end
            PH_QUIET: begin
                emit = (quiet_dec == '0);
            end
            default: begin
                emit     = 1'b0;
                emit_err = 1'b0;
            end
        endcase
        o_result.valid = i_en && (emit || emit_err);
        o_result.error = emit_err;
        o_result.code  = emit_err ? '0 :
                         to_cmd((r_phase == PH_MARK) ? code_mark : r_code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_run    <= '0;
            r_bitpos <= '0;
            r_code   <= '0;
            r_quiet  <= '0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_run    <= n_run;
            r_bitpos <= n_bitpos;
            r_code   <= n_code;
            r_quiet  <= n_quiet;
        end
    end

    // hunting never carries collected bits
    `IRPWD_ASSERT(a_hunt_code_clear, (r_phase != PH_HUNT) || (r_code == '0))
    // the run counter is idle while waiting for quiet
    `IRPWD_ASSERT(a_quiet_run_zero, (r_phase != PH_QUIET) || (r_run == '0))
    // a result always sends the machine back to hunting
    `IRPWD_ASSERT(a_result_to_hunt, o_result.valid |=> (r_phase == PH_HUNT))

endmodule

`default_nettype wire

// ----- rtl/irpwd_out.sv -----
// ----------------------------------------------------------------------------
// irpwd_out
// Result register between the decoder and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ir_pulse_width_command_decoder_defines.svh"

module irpwd_out (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire irpwd_pkg::t_result         i_result,
    input  wire logic                       i_out_ready,
    output logic                            o_in_ready,
    output logic                            o_valid,
    output logic [irpwd_pkg::CMD_W-1:0]     o_code,
    output logic                            o_error
);
    import irpwd_pkg::*;

    logic             r_valid, n_valid;
    logic [CMD_W-1:0] r_code;
    logic             r_error;

    // space for a new result when empty or draining this cycle
    assign o_in_ready = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_result.valid) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, loaded with each new result
    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_code  <= i_result.code;
            r_error <= i_result.error;
        end
    end

    assign o_valid = r_valid;
    assign o_code  = r_code;
    assign o_error = r_error;

    // a result arrives only when there is room for it
    `IRPWD_NEVER(a_no_overwrite, i_result.valid && !o_in_ready)
    // a loaded result is visible next cycle
    `IRPWD_ASSERT(a_load_shows, i_result.valid |=> r_valid)

endmodule

`default_nettype wire

// ----- test/tb_ir_pulse_width_command_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_ir_pulse_width_command_decoder
// Self-checking bench for the IR command decoder. Line samples go in through
// the input stream from a queue, and a cycle-level model of the frame
// decoder predicts each command or framing error. Every output transfer is
// compared with the oldest prediction. Directed frames cover the register
// extremes and corner cases. Random phases follow with fresh register
// settings, well-formed frames, broken frames and line noise. Idle gaps on
// the sender and stalls on the receiver are random.
// ----------------------------------------------------------------------------
module tb_ir_pulse_width_command_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import irpwd_pkg::*;

    localparam int HALF_PERIOD      = 10;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS      = 40;
    localparam int RUN_LIMIT_NS     = 10_000_000;
    localparam int SAMPLE_TARGET    = 1000;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0] code;
        logic             frame_err;
    } t_ir_cmd;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [0] line_level
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // [6:0] command_code
    logic                 m_axis_tuser;         // [0] frame_error
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [TICK_W-1:0]    i_cfg_wdata   = '0;

    ir_pulse_width_command_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // register copies used by the decoder model
    logic [TICK_W-1:0] lim_start_min;
    logic [TICK_W-1:0] lim_start_max;
    logic [TICK_W-1:0] lim_space_max;
    logic [TICK_W-1:0] lim_one_min;
    logic [TICK_W-1:0] lim_quiet_init;
    logic [TICK_W-1:0] lim_quiet_reload;

    // decoder model state
    t_phase            frame_phase;
    logic [TICK_W-1:0] run_len;
    logic [7:0]        bit_idx;
    logic [15:0]       code_acc;
    logic [TICK_W-1:0] quiet_left;

    t_ir_cmd     pending_cmds[$];
    logic        line_samples[$];
    bit          sample_taken    = 1'b0;
    int unsigned samples_queued  = 0;
    int unsigned fail_count      = 0;
    int unsigned reports         = 0;
    int unsigned hold_req        = 0;
    int unsigned hold_done       = 0;
    int unsigned hold_left       = 0;
    int unsigned stall_tick      = 0;
    int unsigned burst_left      = 0;
    int unsigned gap_left        = 0;

    initial begin
        forever #(HALF_PERIOD) i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------
    function automatic logic [TICK_W-1:0] run_step(input logic [TICK_W-1:0] v);
        return (v == {TICK_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    task automatic return_to_hunt();
        frame_phase = PH_HUNT;
        run_len     = '0;
        bit_idx     = '0;
        code_acc    = '0;
        quiet_left  = '0;
    endtask

    task automatic decode_sample(input logic level, output bit emit, output t_ir_cmd cmd);
        bit low;
        bit space_check;
        bit quiet_check;
        low         = (level == 1'b0);
        space_check = 1'b0;
        quiet_check = 1'b0;
        emit        = 1'b0;
        cmd         = '0;
        case (frame_phase)
            PH_HUNT: begin
                if (low) begin
                    run_len = run_step(run_len);
                end else if (run_len != 0 && run_len >= lim_start_min &&
                             run_len <= lim_start_max) begin
                    frame_phase = PH_SPACE;
                    run_len     = 8'd1;
                    bit_idx     = '0;
                    code_acc    = '0;
                    space_check = 1'b1;
                end else begin
                    run_len = '0;
                end
            end
            PH_SPACE: begin
                if (low) begin
                    frame_phase = PH_MARK;
                    run_len     = 8'd1;
                end else begin
                    run_len     = run_step(run_len);
                    space_check = 1'b1;
                end
            end
            PH_MARK: begin
                if (low) begin
                    run_len = run_step(run_len);
                end else begin
                    if (run_len >= lim_one_min && bit_idx < 16)
                        code_acc[bit_idx] = 1'b1;
                    bit_idx = bit_idx + 1'b1;
                    // the high ending the mark opens the next space or the quiet count
                    if (bit_idx < CODE_BITS) begin
                        frame_phase = PH_SPACE;
                        run_len     = 8'd1;
                        space_check = 1'b1;
                    end else begin
                        frame_phase = PH_QUIET;
                        run_len     = '0;
                        quiet_left  = lim_quiet_init;
                        quiet_check = 1'b1;
                    end
                end
            end
            PH_QUIET: begin
                quiet_check = 1'b1;
            end
            default: begin
                return_to_hunt();
            end
        endcase
        // space ran too long
        if (space_check && run_len > lim_space_max) begin
            return_to_hunt();
            emit          = 1'b1;
            cmd.frame_err = 1'b1;
        end
        // quiet tick, any low reloads the reload count
        if (quiet_check) begin
            if (low)
                quiet_left = lim_quiet_reload;
            if (quiet_left > 0)
                quiet_left = quiet_left - 1'b1;
            if (quiet_left == 0) begin
                emit     = 1'b1;
                cmd.code = code_acc[CMD_W-1:0];
                return_to_hunt();
            end
        end
    endtask

    task automatic note_mismatch(input string msg);
        fail_count++;
        if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: %s", $time, msg);
        end
    endtask

    // ------------------------------------------------------------------------
    // monitor: model update on input transfers, check on output transfers
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit      emit;
        t_ir_cmd next_cmd;
        t_ir_cmd want;
        t_ir_cmd got;
        if (!i_rst_n) begin
            lim_start_min    = RST_START_MIN;
            lim_start_max    = RST_START_MAX;
            lim_space_max    = RST_SPACE_MAX;
            lim_one_min      = RST_ONE_MIN;
            lim_quiet_init   = RST_QUIET_INIT;
            lim_quiet_reload = RST_QUIET_RELOAD;
            return_to_hunt();
            pending_cmds.delete();
            sample_taken = 1'b0;
        end else begin
            // input transfer
            sample_taken = (s_axis_tvalid && s_axis_tready === 1'b1);
            if (sample_taken) begin
                decode_sample(s_axis_tdata[0], emit, next_cmd);
                if (emit)
                    pending_cmds.push_back(next_cmd);
            end
            // output transfer
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                got.code      = m_axis_tdata[CMD_W-1:0];
                got.frame_err = m_axis_tuser;
                if (pending_cmds.size() == 0) begin
                    note_mismatch($sformatf("unexpected transfer, expected none, actual code %0h error %0b",
                                            got.code, got.frame_err));
                end else begin
                    want = pending_cmds.pop_front();
                    if (got.code !== want.code)
                        note_mismatch($sformatf("command_code expected %0h, actual %0h",
                                                want.code, got.code));
                    if (got.frame_err !== want.frame_err)
                        note_mismatch($sformatf("frame_error expected %0b, actual %0b",
                                                want.frame_err, got.frame_err));
                end
            end
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_MIN:    lim_start_min    = i_cfg_wdata;
                    CFG_START_MAX:    lim_start_max    = i_cfg_wdata;
                    CFG_SPACE_MAX:    lim_space_max    = i_cfg_wdata;
                    CFG_ONE_MIN:      lim_one_min      = i_cfg_wdata;
                    CFG_QUIET_INIT:   lim_quiet_init   = i_cfg_wdata;
                    CFG_QUIET_RELOAD: lim_quiet_reload = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // sample driver: bursts of random length with random gaps
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic next_valid;
        logic next_level;
        next_valid = s_axis_tvalid;
        next_level = s_axis_tdata[0];
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!s_axis_tvalid || sample_taken) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (line_samples.size() > 0) begin
                next_valid = 1'b1;
                next_level = line_samples.pop_front();
                if (burst_left > 0)
                    burst_left--;
                // burst done, pick the next burst and the gap before it
                if (burst_left == 0) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            burst_left = $urandom_range(100, 300);
                            gap_left   = 0;
                        end
                        1, 2: begin
                            burst_left = $urandom_range(1, 20);
                            gap_left   = $urandom_range(1, 5);
                        end
                        default: begin
                            burst_left = $urandom_range(1, 8);
                            gap_left   = $urandom_range(6, 20);
                        end
                    endcase
                end
            end
        end
        s_axis_tvalid <= next_valid;
        s_axis_tdata  <= {7'b0, next_level};
    end

    // ------------------------------------------------------------------------
    // command receiver: rotating stall pattern plus requested long hold-offs
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic next_ready;
        stall_tick++;
        if (!i_rst_n) begin
            next_ready = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else if (hold_done != hold_req) begin
            hold_done  = hold_req;
            hold_left  = LONG_HOLD_CYCLES - 1;
            next_ready = 1'b0;
        end else begin
            case ((stall_tick / 128) % 4)
                0:       next_ready = 1'b1;
                1:       next_ready = 1'($urandom_range(0, 1));
                2:       next_ready = (stall_tick % 5 == 0);
                default: next_ready = ($urandom_range(0, 7) != 0);
            endcase
        end
        m_axis_tready <= next_ready;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_run(input logic level, input int unsigned n);
        repeat (n) line_samples.push_back(level);
        samples_queued += n;
    endtask

    task automatic add_noise(input int unsigned n);
        int unsigned bias;
        bias = $urandom_range(1, 3);
        repeat (n) line_samples.push_back($urandom_range(0, 3) < bias);
        samples_queued += n;
    endtask

    // one frame at the current settings; the space before mark break_at runs long
    task automatic add_frame(input logic [15:0] code, input int unsigned start_len,
                             input int break_at, input bit quiet_dip);
        int unsigned lo;
        int unsigned hi;
        int unsigned n;
        int unsigned q;
        add_run(1'b1, $urandom_range(1, 3));
        if (start_len == 0) begin
            lo = lim_start_min;
            hi = lim_start_max;
            if (lo == 0 || lo > hi)
                start_len = $urandom_range(1, 10);
            else
                start_len = lo + $urandom_range(0, (hi - lo > 4) ? 4 : hi - lo);
        end
        add_run(1'b0, start_len);
        for (int b = 0; b < CODE_BITS; b++) begin
            // space; the high ending the previous mark is its first tick
            if (b == break_at)
                n = lim_space_max + 1 + $urandom_range(0, 2);
            else if (lim_space_max <= 1)
                n = 1;
            else
                n = $urandom_range(1, (lim_space_max > 4) ? 4 : lim_space_max);
            add_run(1'b1, n);
            // mark, long for a one
            if (code[b])
                n = ((lim_one_min == 0) ? 1 : lim_one_min) + $urandom_range(0, 2);
            else if (lim_one_min <= 1)
                n = 1;
            else if ($urandom_range(0, 1))
                n = lim_one_min - 1;
            else
                n = $urandom_range(1, (lim_one_min - 1 > 4) ? 4 : lim_one_min - 1);
            add_run(1'b0, n);
        end
        // quiet stretch, optionally broken by a low dip
        q = (lim_quiet_init == 0) ? 1 : lim_quiet_init;
        if (quiet_dip) begin
            add_run(1'b1, $urandom_range(1, q));
            add_run(1'b0, $urandom_range(1, 2));
            q = (lim_quiet_reload == 0) ? 1 : lim_quiet_reload;
        end
        add_run(1'b1, q + $urandom_range(0, 2));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
    endtask

    task automatic load_settings(input logic [TICK_W-1:0] smin, input logic [TICK_W-1:0] smax,
                                 input logic [TICK_W-1:0] spmax, input logic [TICK_W-1:0] onemin,
                                 input logic [TICK_W-1:0] qinit, input logic [TICK_W-1:0] qreload);
        write_reg(CFG_START_MIN, smin);
        write_reg(CFG_START_MAX, smax);
        write_reg(CFG_SPACE_MAX, spmax);
        write_reg(CFG_ONE_MIN, onemin);
        write_reg(CFG_QUIET_INIT, qinit);
        write_reg(CFG_QUIET_RELOAD, qreload);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // sender drained, every command back, then a settling wait
    task automatic wait_idle();
        @(posedge i_clk);
        while (line_samples.size() != 0 || s_axis_tvalid || pending_cmds.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase_start;
        int unsigned pick;
        logic [TICK_W-1:0] smin;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: all-zero and all-one codes, a broken last space, noise
        add_frame(16'h0000, 0, -1, 1'b0);
        add_frame(16'hFFFF, 0, -1, 1'b0);
        add_frame(16'($urandom), 0, CODE_BITS - 1, 1'b0);
        add_noise(20);
        wait_idle();

        // zero space limit; start_min of zero still needs a low run
        load_settings(8'd0, 8'd4, 8'd0, 8'd3, 8'd4, 8'd6);
        add_run(1'b1, 3);
        add_run(1'b0, 2);
        add_run(1'b1, 3);
        add_frame(16'($urandom), 0, -1, 1'b0);
        wait_idle();

        // start window out of order: nothing is ever accepted
        load_settings(8'd8, 8'd3, 8'd3, 8'd3, 8'd4, 8'd6);
        add_run(1'b0, 5);
        add_run(1'b1, 2);
        add_run(1'b0, 9);
        add_run(1'b1, 2);
        add_frame(16'($urandom), 5, -1, 1'b0);
        wait_idle();

        // zero quiet counts emit at once, a reload of one emits on the low
        load_settings(8'd1, 8'd4, 8'd2, 8'd2, 8'd0, 8'd0);
        add_frame(16'($urandom), 0, -1, 1'b0);
        add_frame(16'($urandom), 0, -1, 1'b1);
        wait_idle();
        load_settings(8'd1, 8'd4, 8'd2, 8'd2, 8'd4, 8'd1);
        add_frame(16'($urandom), 0, -1, 1'b1);
        add_frame(16'($urandom), 0, -1, 1'b1);
        wait_idle();

        // writes to unused indexes must change nothing
        write_reg(CFG_SPARE_A, TICK_W'($urandom));
        write_reg(CFG_SPARE_B, TICK_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        add_frame(16'($urandom), 0, -1, 1'b0);
        wait_idle();

        // start window and space limit at maximum, start run past saturation
        load_settings(8'hFF, 8'hFF, 8'hFF, 8'd3, 8'd8, 8'd12);
        add_frame(16'($urandom), 260, -1, 1'b0);
        wait_idle();

        // random phases
        for (int ph = 0; ph < 40 && (ph < 2 || samples_queued < SAMPLE_TARGET); ph++) begin
            if (ph != 1 && $urandom_range(0, 5) == 0) begin
                load_settings(TICK_W'($urandom), TICK_W'($urandom), TICK_W'($urandom),
                              TICK_W'($urandom), TICK_W'($urandom), TICK_W'($urandom));
            end else begin
                smin = TICK_W'($urandom_range(1, 8));
                load_settings(smin, smin + TICK_W'($urandom_range(0, 4)),
                              TICK_W'($urandom_range(1, 4)), TICK_W'($urandom_range(1, 4)),
                              TICK_W'($urandom_range(0, 24)), TICK_W'($urandom_range(0, 32)));
            end
            if (ph == 1) begin
                // receiver holds off while error frames keep coming
                hold_req++;
                repeat (4) add_frame(16'($urandom), 0, $urandom_range(0, CODE_BITS - 1), 1'b0);
            end else begin
                phase_start = samples_queued;
                while (samples_queued - phase_start < 150) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        add_frame(16'($urandom), 0, -1, pick == 0);
                    else if (pick < 9)
                        add_frame(16'($urandom), 0, $urandom_range(0, CODE_BITS - 1), 1'b0);
                    else
                        add_noise($urandom_range(5, 40));
                end
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
